@@ design/bdq_pkg.sv @@
// Shared types and constants for the bounded deque core.
// Used by the controller, the datapath, the top level and the port checker.
package bdq_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int DATA_W           = 32;
   localparam int OP_W             = 3;
   localparam int STATUS_W         = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_SET_FRONT  = 3'd4,
      OP_SET_BACK   = 3'd5,
      OP_TRAVERSE   = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE  = 2'd0,
      STAT_ELEM  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_FULL  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_PUSH_FRONT,
      CMD_PUSH_BACK,
      CMD_POP_FRONT,
      CMD_POP_BACK,
      CMD_SET_FRONT,
      CMD_SET_BACK,
      CMD_TRAV_START,
      CMD_TRAV_STEP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic trav_last;
   } dp_status_type;

endpackage

@@ design/bounded_deque_with_traversal_core.sv @@
// Top level of the bounded deque core: controller plus ring datapath.
// Depends on bdq_pkg, bdq_ctrl and bdq_datapath.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+------------------------
//   request  | start, busy, req_op, req_value          | taken when start & !busy
//   result   | rsp_strobe, rsp_status, rsp_element,    | one cycle per strobe,
//            | rsp_last                                | no back-pressure
//
// Push, pop and set: the result strobes the cycle after the item is taken.
// Traverse holds busy until its final entry; the single read port of the entry
// memory delivers one entry per cycle, front to back, with rsp_last on the final one.
// Synchronous reset empties the queue; entry contents are left as they are.
// The receiver cannot stall; results are never held.
module bounded_deque_with_traversal_core #(
   parameter int CAPACITY = bdq_pkg::DEFAULT_CAPACITY
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [bdq_pkg::OP_W-1:0]           req_op,
   input  logic signed [bdq_pkg::DATA_W-1:0]  req_value,
   output logic                               rsp_strobe,
   output logic [bdq_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [bdq_pkg::DATA_W-1:0]  rsp_element,
   output logic                               rsp_last
);
   import bdq_pkg::*;

   cmd_type       cmd;
   dp_status_type dp_status;

   bdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .op         (req_op),
      .dp_status  (dp_status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

   bdq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .value   (req_value),
      .status  (dp_status),
      .element (rsp_element)
   );

endmodule

@@ design/bdq_datapath.sv @@
// Datapath: ring of entries, front pointer, occupancy and traverse walker.
// Depends on bdq_pkg; driven by bdq_ctrl commands.
module bdq_datapath #(
   parameter int CAPACITY = bdq_pkg::DEFAULT_CAPACITY
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bdq_pkg::cmd_type             cmd,
   input  logic signed [bdq_pkg::DATA_W-1:0] value,
   output bdq_pkg::dp_status_type       status,
   output logic signed [bdq_pkg::DATA_W-1:0] element
);
   import bdq_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SUM_W = CNT_W + 1;

   logic [DATA_W-1:0] mem [CAPACITY];

   logic [IDX_W-1:0]  front_ff, front_in;
   logic [CNT_W-1:0]  occ_ff, occ_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] rdata_ff;
   logic [DATA_W-1:0] elem_ff, elem_in;

   logic [IDX_W-1:0]  front_dec, front_inc, pos_inc;
   logic [SUM_W-1:0]  tail_sum, back_sum;
   logic [IDX_W-1:0]  tail_pos, back_pos;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   logic              wr_en;

   assign front_dec = (front_ff == '0) ? IDX_W'(CAPACITY - 1) : front_ff - 1'b1;
   assign front_inc = (front_ff == IDX_W'(CAPACITY - 1)) ? '0 : front_ff + 1'b1;
   assign pos_inc   = (pos_ff == IDX_W'(CAPACITY - 1)) ? '0 : pos_ff + 1'b1;

   assign tail_sum = SUM_W'(front_ff) + SUM_W'(occ_ff);
   assign back_sum = tail_sum - 1'b1;
   assign tail_pos = (tail_sum >= SUM_W'(CAPACITY)) ? IDX_W'(tail_sum - SUM_W'(CAPACITY))
                                                    : IDX_W'(tail_sum);
   assign back_pos = (back_sum >= SUM_W'(CAPACITY)) ? IDX_W'(back_sum - SUM_W'(CAPACITY))
                                                    : IDX_W'(back_sum);

   assign status.empty     = (occ_ff == '0);
   assign status.full      = (occ_ff >= CNT_W'(CAPACITY));
   assign status.trav_last = ((CNT_W'(cnt_ff) + 1'b1) == occ_ff);

   always_comb begin
      front_in = front_ff;
      occ_in   = occ_ff;
      pos_in   = pos_ff;
      cnt_in   = cnt_ff;
      elem_in  = '0;
      wr_en    = 1'b0;
      wr_addr  = front_ff;
      rd_addr  = pos_ff;
      case (cmd.kind)
         CMD_PUSH_FRONT: begin
            front_in = front_dec;
            occ_in   = occ_ff + 1'b1;
            wr_en    = 1'b1;
            wr_addr  = front_dec;
         end
         CMD_PUSH_BACK: begin
            occ_in  = occ_ff + 1'b1;
            wr_en   = 1'b1;
            wr_addr = tail_pos;
         end
         CMD_POP_FRONT: begin
            front_in = front_inc;
            occ_in   = occ_ff - 1'b1;
         end
         CMD_POP_BACK: begin
            occ_in = occ_ff - 1'b1;
         end
         CMD_SET_FRONT: begin
            wr_en   = 1'b1;
            wr_addr = front_ff;
         end
         CMD_SET_BACK: begin
            wr_en   = 1'b1;
            wr_addr = back_pos;
         end
         CMD_TRAV_START: begin
            rd_addr = front_ff;
            pos_in  = front_inc;
            cnt_in  = '0;
         end
         CMD_TRAV_STEP: begin
            elem_in = rdata_ff;
            pos_in  = pos_inc;
            cnt_in  = cnt_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= value;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         occ_ff   <= '0;
      end else begin
         front_ff <= front_in;
         occ_ff   <= occ_in;
      end
      pos_ff  <= pos_in;
      cnt_ff  <= cnt_in;
      elem_ff <= elem_in;
   end

   assign element = elem_ff;

endmodule

@@ design/bdq_ctrl.sv @@
// Controller: decodes requests, sequences traverse, registers the result strobe.
// Depends on bdq_pkg; commands bdq_datapath.
module bdq_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bdq_pkg::OP_W-1:0]      op,
   input  bdq_pkg::dp_status_type        dp_status,
   output bdq_pkg::cmd_type              cmd,
   output logic                          busy,
   output logic                          rsp_strobe,
   output logic [bdq_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_last
);
   import bdq_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_TRAV
   } state_type;

   state_type  state_ff, state_in;
   logic       strobe_ff, strobe_in;
   status_type status_ff, status_in;
   logic       last_ff, last_in;

   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      status_in = status_ff;
      last_in   = last_ff;
      cmd.kind  = CMD_NONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               strobe_in = 1'b1;
               last_in   = 1'b1;
               status_in = STAT_DONE;
               case (op)
                  OP_PUSH_FRONT: begin
                     if (dp_status.full) status_in = STAT_FULL;
                     else cmd.kind = CMD_PUSH_FRONT;
                  end
                  OP_PUSH_BACK: begin
                     if (dp_status.full) status_in = STAT_FULL;
                     else cmd.kind = CMD_PUSH_BACK;
                  end
                  OP_POP_FRONT: begin
                     if (dp_status.empty) status_in = STAT_EMPTY;
                     else cmd.kind = CMD_POP_FRONT;
                  end
                  OP_POP_BACK: begin
                     if (dp_status.empty) status_in = STAT_EMPTY;
                     else cmd.kind = CMD_POP_BACK;
                  end
                  OP_SET_FRONT: begin
                     if (dp_status.empty) status_in = STAT_EMPTY;
                     else cmd.kind = CMD_SET_FRONT;
                  end
                  OP_SET_BACK: begin
                     if (dp_status.empty) status_in = STAT_EMPTY;
                     else cmd.kind = CMD_SET_BACK;
                  end
                  OP_TRAVERSE: begin
                     if (dp_status.empty) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        strobe_in = 1'b0;
                        cmd.kind  = CMD_TRAV_START;
                        state_in  = S_TRAV;
                     end
                  end
                  default: begin
                     strobe_in = 1'b0;
                  end
               endcase
            end
         end
         S_TRAV: begin
            cmd.kind  = CMD_TRAV_STEP;
            strobe_in = 1'b1;
            status_in = STAT_ELEM;
            last_in   = dp_status.trav_last;
            if (dp_status.trav_last) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_status = status_ff;
   assign rsp_last   = last_ff;

endmodule

@@ design/bdq_checker.sv @@
// Port-level checker for the bounded deque core, bound to the top level.
// Depends on bdq_pkg and bounded_deque_with_traversal_core.
module bdq_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic [bdq_pkg::OP_W-1:0]           req_op,
   input logic                               rsp_strobe,
   input logic [bdq_pkg::STATUS_W-1:0]       rsp_status,
   input logic signed [bdq_pkg::DATA_W-1:0]  rsp_element,
   input logic                               rsp_last
);
   import bdq_pkg::*;

   a_single_has_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status != STAT_ELEM) |-> rsp_last && (rsp_element == '0))
      else $error("non-traverse item without last or with nonzero element");

   a_simple_answers: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_op != OP_TRAVERSE) && (req_op <= OP_SET_BACK)
      |=> rsp_strobe && rsp_last && (rsp_status != STAT_ELEM))
      else $error("simple request not answered next cycle");

   a_walk_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe && (rsp_status == STAT_ELEM))
      else $error("traverse stopped before last");

   a_busy_from_traverse: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && (req_op == OP_TRAVERSE)))
      else $error("busy raised without a traverse");

endmodule

bind bounded_deque_with_traversal_core bdq_checker u_bdq_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_op      (req_op),
   .rsp_strobe  (rsp_strobe),
   .rsp_status  (rsp_status),
   .rsp_element (rsp_element),
   .rsp_last    (rsp_last)
);

@@ bench/tb_bounded_deque_with_traversal_core.sv @@
// Self-checking bench for the bounded deque core: directed corner items, then
// biased random fill/drain traffic, with results checked against a ring predictor.
// Depends on bdq_pkg and bounded_deque_with_traversal_core.

class deque_scoreboard #(int DEPTH = 16);
   typedef struct {
      bdq_pkg::status_type status;
      logic signed [31:0]  element;
      logic                last;
   } response_type;

   response_type       pending_results[$];
   logic signed [31:0] ring[DEPTH];
   int unsigned        front_pos;
   int unsigned        held;
   int                 failures;

   function new();
      front_pos = 0;
      held      = 0;
      failures  = 0;
   endfunction

   function void queue_response(bdq_pkg::status_type status, logic signed [31:0] element,
                                logic last);
      response_type r;
      r.status  = status;
      r.element = element;
      r.last    = last;
      pending_results.push_back(r);
   endfunction

   function int unsigned back_pos();
      return (front_pos + held - 1) % DEPTH;
   endfunction

   function void note_request(logic [2:0] op, logic signed [31:0] value);
      case (op)
         bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
            if (held >= DEPTH) begin
               queue_response(bdq_pkg::STAT_FULL, 0, 1'b1);
            end else begin
               if (op == bdq_pkg::OP_PUSH_FRONT) begin
                  front_pos       = (front_pos == 0) ? DEPTH - 1 : front_pos - 1;
                  ring[front_pos] = value;
                  held++;
               end else begin
                  held++;
                  ring[back_pos()] = value;
               end
               queue_response(bdq_pkg::STAT_DONE, 0, 1'b1);
            end
         end
         bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK,
         bdq_pkg::OP_SET_FRONT, bdq_pkg::OP_SET_BACK: begin
            if (held == 0) begin
               queue_response(bdq_pkg::STAT_EMPTY, 0, 1'b1);
            end else begin
               case (op)
                  bdq_pkg::OP_POP_FRONT: begin
                     front_pos = (front_pos + 1) % DEPTH;
                     held--;
                  end
                  bdq_pkg::OP_POP_BACK: held--;
                  bdq_pkg::OP_SET_FRONT: ring[front_pos] = value;
                  default: ring[back_pos()] = value;
               endcase
               queue_response(bdq_pkg::STAT_DONE, 0, 1'b1);
            end
         end
         bdq_pkg::OP_TRAVERSE: begin
            if (held == 0) begin
               queue_response(bdq_pkg::STAT_EMPTY, 0, 1'b1);
            end else begin
               for (int unsigned i = 0; i < held; i++) begin
                  queue_response(bdq_pkg::STAT_ELEM, ring[(front_pos + i) % DEPTH],
                                 (i + 1 == held));
               end
            end
         end
         default: ;
      endcase
   endfunction

   function void check_response(logic [1:0] status, logic signed [31:0] element, logic last);
      response_type want;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected result status %0d element %0d last %0d",
                  $time, status, element, last);
         failures++;
         return;
      end
      want = pending_results.pop_front();
      if (status !== want.status) begin
         $display("%0t: status expected %0d actual %0d", $time, want.status, status);
         failures++;
      end
      if (element !== want.element) begin
         $display("%0t: element expected %0d actual %0d", $time, want.element, element);
         failures++;
      end
      if (last !== want.last) begin
         $display("%0t: last expected %0d actual %0d", $time, want.last, last);
         failures++;
      end
   endfunction

   function int pending();
      return pending_results.size();
   endfunction
endclass

module tb_bounded_deque_with_traversal_core;
   import bdq_pkg::*;

   localparam int          DEPTH       = DEFAULT_CAPACITY;
   localparam logic [2:0]  OP_UNUSED   = 3'd7;
   localparam int          CYCLE_LIMIT = 100000;
   localparam int          PHASE_ITEMS = 48;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic [OP_W-1:0]             req_op;
   logic signed [DATA_W-1:0]    req_value;
   logic                        rsp_strobe;
   logic [STATUS_W-1:0]         rsp_status;
   logic signed [DATA_W-1:0]    rsp_element;
   logic                        rsp_last;

   deque_scoreboard #(DEPTH)    sb;
   int                          cycles = 0;

   bounded_deque_with_traversal_core #(.CAPACITY(DEPTH)) u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_op      (req_op),
      .req_value   (req_value),
      .rsp_strobe  (rsp_strobe),
      .rsp_status  (rsp_status),
      .rsp_element (rsp_element),
      .rsp_last    (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("bounded_deque_with_traversal_core: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_response(rsp_status, rsp_element, rsp_last);
   end

   task automatic send_request(input logic [2:0] op, input logic signed [31:0] value,
                               input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start     <= 1'b1;
      req_op    <= op;
      req_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(op, value);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(11))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return 32'sh0000_0000;
         3: return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [2:0] pick_op(int push_pct);
      int r;
      r = $urandom_range(99);
      if (r < 3) return OP_UNUSED;
      if (r < 11) return OP_TRAVERSE;
      if (r < 23) return $urandom_range(1) ? OP_SET_BACK : OP_SET_FRONT;
      if ($urandom_range(99) < push_pct)
         return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
   endfunction

   initial begin
      int idle_pct;
      int push_pct;

      sb        = new();
      reset     = 1'b1;
      start     = 1'b0;
      req_op    = '0;
      req_value = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_request(OP_TRAVERSE,   0, 22);
      send_request(OP_POP_FRONT,  0, 22);
      send_request(OP_POP_BACK,   0, 22);
      send_request(OP_SET_FRONT,  32'sh1234_5678, 22);
      send_request(OP_SET_BACK,   32'sh1234_5678, 22);
      send_request(OP_UNUSED,     -32'sd1, 22);
      send_request(OP_PUSH_FRONT, 32'sh8000_0000, 22);
      send_request(OP_PUSH_BACK,  32'sh7fff_ffff, 22);
      send_request(OP_TRAVERSE,   0, 22);
      send_request(OP_SET_FRONT,  -32'sd1, 22);
      send_request(OP_SET_BACK,   32'shaaaa_aaaa, 22);
      send_request(OP_TRAVERSE,   0, 22);
      send_request(OP_POP_FRONT,  0, 22);
      send_request(OP_POP_BACK,   0, 22);
      send_request(OP_TRAVERSE,   0, 22);

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 22 : (phase == 1) ? 68 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            push_pct = (n < PHASE_ITEMS / 2) ? 90 : 15;
            send_request(pick_op(push_pct), pick_value(), idle_pct);
         end
      end
      start <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DEPTH + 4) @(posedge clock);

      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("bounded_deque_with_traversal_core: match");
      end else begin
         $display("bounded_deque_with_traversal_core: mismatch");
      end
      $finish;
   end
endmodule

@@ bounded_deque_with_traversal_core.f @@
design/bdq_pkg.sv
design/bdq_datapath.sv
design/bdq_ctrl.sv
design/bounded_deque_with_traversal_core.sv
design/bdq_checker.sv
bench/tb_bounded_deque_with_traversal_core.sv
